// File: sv/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// shared constants, tables and the lps function for the streebog hash core
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int RoundCount    = 12;
  localparam int WordsPerBlock = 8;
  localparam int VecW          = 512;
  localparam int WordW         = 64;

  localparam logic [VecW-1:0] IV_256 = {64{8'h01}};
  localparam logic [9:0]      BLOCK_BITS = 10'd512;

  // register addresses
  localparam logic [0:0] REG_DIGEST_IS_512 = 1'b0;

  localparam logic [7:0] SBOX [256] = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,8'd251,8'd196,8'd250,8'd218,
    8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,8'd23,8'd54,8'd241,8'd187,
    8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,8'd129,8'd28,8'd60,8'd66,
    8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,8'd6,8'd11,8'd237,8'd152,
    8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,8'd242,8'd42,8'd104,8'd162,
    8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,8'd191,8'd114,8'd19,8'd71,
    8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,8'd243,8'd145,8'd120,8'd111,
    8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,8'd109,8'd84,8'd198,8'd128,
    8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,8'd215,8'd121,8'd214,8'd246,
    8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,8'd220,8'd232,8'd40,8'd80,
    8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,8'd26,8'd184,8'd56,8'd130,
    8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,8'd140,8'd163,8'd165,8'd125,
    8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,8'd48,8'd55,8'd107,8'd228,
    8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,8'd141,8'd83,8'd170,8'd144,
    8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,8'd203,8'd155,8'd37,8'd208,
    8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,8'd209,8'd102,8'd175,8'd194,
    8'd57,8'd75,8'd99,8'd182
  };

  localparam logic [63:0] LIN [64] = '{
    64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
    64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
    64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
    64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
    64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
    64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
    64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
    64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
    64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
    64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
    64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
    64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
    64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
    64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
    64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
    64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
  };

  // most significant word first, so word j holds row entry 7-j
  localparam logic [VecW-1:0] RC [RoundCount] = '{
    {64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
     64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
    {64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
     64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
    {64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
     64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
    {64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
     64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
    {64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
     64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
    {64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
     64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
    {64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
     64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
    {64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
     64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
    {64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
     64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
    {64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
     64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
    {64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
     64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
    {64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
     64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}
  };

  typedef struct packed {
    logic                start;
    logic [VecW-1:0]     h;
    logic [VecW-1:0]     m;
    logic [VecW-1:0]     n;
  } comp_req_t;

  typedef struct packed {
    logic                done;
    logic [VecW-1:0]     h;
  } comp_rsp_t;

  function automatic logic [63:0] lin_lane(input logic [63:0] t);
    logic [63:0] r;
    r = '0;
    for (int q = 0; q < 64; q++) begin
      if (t[q]) r = r ^ LIN[63-q];
    end
    return r;
  endfunction

  function automatic logic [VecW-1:0] lps(input logic [VecW-1:0] a);
    logic [63:0]     t;
    logic [VecW-1:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      t = '0;
      for (int b = 0; b < 8; b++) begin
        t[8*b +: 8] = SBOX[a[64*b + 8*j +: 8]];
      end
      r[64*j +: 64] = lin_lane(t);
    end
    return r;
  endfunction

endpackage

// File: sv/stb_in_if.sv
// ----------------------------------------------------------------------------
// stb_in_if
// message word channel
// ----------------------------------------------------------------------------
interface stb_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic        first_of_message;
  logic        final_block;
  logic [5:0]  tail_bytes;

  modport source (output valid, message_word, first_of_message, final_block, tail_bytes,
                  input ready);
  modport sink (input valid, message_word, first_of_message, final_block, tail_bytes,
                output ready);
endinterface

// File: sv/stb_out_if.sv
// ----------------------------------------------------------------------------
// stb_out_if
// digest word channel
// ----------------------------------------------------------------------------
interface stb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;

  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

// File: sv/stb_lps.sv
// ----------------------------------------------------------------------------
// stb_lps
// shared lps unit: substitution, byte transposition and linear mix
// ----------------------------------------------------------------------------
module stb_lps (
  input  logic [stb_pkg::VecW-1:0] din,
  output logic [stb_pkg::VecW-1:0] dout
);
  assign dout = stb_pkg::lps(din);
endmodule

// File: sv/stb_comp.sv
// ----------------------------------------------------------------------------
// stb_comp
// compression g_n: one lps a cycle, alternating state and key
// ----------------------------------------------------------------------------
module stb_comp (
  input  logic               clk,
  input  logic               rst_n,
  input  stb_pkg::comp_req_t req,
  output stb_pkg::comp_rsp_t rsp
);
  typedef enum logic [1:0] {C_IDLE, C_INIT, C_RND, C_FIN} cstate_t;

  cstate_t                  state_r;
  logic [3:0]               rnd_r;
  logic                     ph_r;
  logic [stb_pkg::VecW-1:0] key_r;
  logic [stb_pkg::VecW-1:0] st_r;
  logic [stb_pkg::VecW-1:0] h_r;
  logic                     done_r;
  logic [stb_pkg::VecW-1:0] lps_in;
  logic [stb_pkg::VecW-1:0] lps_out;

  always_comb begin
    case (state_r)
      C_INIT:  lps_in = req.h ^ req.n;
      C_RND:   lps_in = ph_r ? (key_r ^ stb_pkg::RC[rnd_r]) : (st_r ^ key_r);
      default: lps_in = key_r;
    endcase
  end

  stb_lps u_lps (.din(lps_in), .dout(lps_out));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
      ph_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == C_FIN);
      case (state_r)
        C_IDLE: begin
          if (req.start) state_r <= C_INIT;
        end
        C_INIT: begin
          key_r   <= lps_out;
          st_r    <= req.m;
          rnd_r   <= '0;
          ph_r    <= 1'b0;
          state_r <= C_RND;
        end
        C_RND: begin
          ph_r <= ~ph_r;
          if (!ph_r) begin
            st_r <= lps_out;
          end else begin
            key_r <= lps_out;
            if (rnd_r == 4'(stb_pkg::RoundCount - 1)) state_r <= C_FIN;
            else rnd_r <= rnd_r + 4'd1;
          end
        end
        C_FIN: begin
          h_r     <= req.h ^ st_r ^ key_r ^ req.m;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.h    = h_r;
endmodule

// File: sv/streebog_hash_core.sv
// ----------------------------------------------------------------------------
// streebog_hash_core
// streebog hash, 512 or 256 bit digest, over 64-bit message words
// ----------------------------------------------------------------------------
// one word per request while a block fills; the eighth word starts g_n,
// one compression is 25 lps passes, then word-serial adds update count and sum
// a final block costs three compressions plus adds before the first digest
// word, then 8 or 4 words; the block takes no input during that work
// rst_n synchronous: zero chain value (512-bit iv), zero count and sum
// ----------------------------------------------------------------------------
module streebog_hash_core (
  input  logic         clk,
  input  logic         rst_n,
  stb_in_if.sink       in_ch,
  stb_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [0:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  typedef enum logic [2:0] {S_IDLE, S_COMP_M, S_ADD, S_COMP_N, S_COMP_S, S_OUT} state_t;

  state_t                   state_r;
  logic                     is512_r;
  logic [2:0]               pos_r;
  logic [2:0]               cnt_r;
  logic                     final_r;
  logic [9:0]               incr_r;
  logic                     cy_n_r;
  logic                     cy_s_r;
  logic                     start_r;
  logic                     start_nxt;
  logic [stb_pkg::VecW-1:0] h_r;
  logic [stb_pkg::VecW-1:0] n_r;
  logic [stb_pkg::VecW-1:0] s_r;
  logic [stb_pkg::VecW-1:0] buf_r;
  logic                     out_valid_r;
  logic [63:0]              out_word_r;
  logic                     out_last_r;

  stb_pkg::comp_req_t       creq;
  stb_pkg::comp_rsp_t       crsp;

  logic                     in_acc;
  logic                     out_acc;
  logic                     first;
  logic [2:0]               pos_eff;
  logic [stb_pkg::VecW-1:0] blk_full;
  logic [stb_pkg::VecW-1:0] blk_masked;
  logic [stb_pkg::VecW-1:0] iv;
  logic [63:0]              n_word;
  logic [63:0]              s_word;
  logic [63:0]              b_word;
  logic [63:0]              inc_word;
  logic [64:0]              sum_n;
  logic [64:0]              sum_s;
  logic [2:0]               last_idx;
  logic [2:0]               nxt_cnt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, is512_r};

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign first   = in_ch.first_of_message;
  assign pos_eff = first ? 3'd0 : pos_r;
  assign iv      = is512_r ? '0 : stb_pkg::IV_256;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.digest_last = out_last_r;

  // last word of a block lands in word 0
  assign blk_full = {buf_r[511:64], in_ch.message_word};

  always_comb begin
    logic signed [7:0] keep;
    logic [63:0]       w;
    blk_masked = blk_full;
    for (int j = 0; j < 8; j++) begin
      keep = $signed({2'b00, in_ch.tail_bytes}) - 8'(8*j);
      w    = blk_full[64*j +: 64];
      if (keep <= 0) w = '0;
      else if (keep < 8) w = w & ~({64{1'b1}} << {keep[2:0], 3'b000});
      if (in_ch.tail_bytes[5:3] == 3'(j)) w = w | (64'd1 << {in_ch.tail_bytes[2:0], 3'b000});
      blk_masked[64*j +: 64] = w;
    end
  end

  always_comb begin
    creq.start = start_r;
    creq.h     = h_r;
    case (state_r)
      S_COMP_N: begin
        creq.m = n_r;
        creq.n = '0;
      end
      S_COMP_S: begin
        creq.m = s_r;
        creq.n = '0;
      end
      default: begin
        creq.m = buf_r;
        creq.n = n_r;
      end
    endcase
  end

  stb_comp u_comp (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  assign n_word   = n_r[cnt_r*64 +: 64];
  assign s_word   = s_r[cnt_r*64 +: 64];
  assign b_word   = buf_r[cnt_r*64 +: 64];
  assign inc_word = (cnt_r == 3'd0) ? {54'd0, incr_r} : 64'd0;
  assign sum_n    = {1'b0, n_word} + {1'b0, inc_word} + {64'd0, cy_n_r};
  assign sum_s    = {1'b0, s_word} + {1'b0, b_word} + {64'd0, cy_s_r};
  assign last_idx = is512_r ? 3'd7 : 3'd3;
  assign nxt_cnt  = cnt_r + 3'd1;

  // compression start pulse
  assign start_nxt =
    (state_r == S_IDLE && in_acc && pos_eff == 3'(stb_pkg::WordsPerBlock - 1)) ||
    (state_r == S_ADD && cnt_r == 3'd7 && final_r) ||
    (state_r == S_COMP_N && crsp.done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      is512_r     <= 1'b1;
      pos_r       <= '0;
      cnt_r       <= '0;
      h_r         <= '0;
      n_r         <= '0;
      s_r         <= '0;
      out_valid_r <= 1'b0;
      final_r     <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      start_r <= start_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == stb_pkg::REG_DIGEST_IS_512) begin
        is512_r <= cfg_pwdata[0];
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (first) begin
              h_r <= iv;
              n_r <= '0;
              s_r <= '0;
            end
            if (pos_eff != 3'(stb_pkg::WordsPerBlock - 1)) begin
              buf_r[(3'd7 - pos_eff)*64 +: 64] <= in_ch.message_word;
              pos_r <= pos_eff + 3'd1;
            end else begin
              pos_r   <= '0;
              final_r <= in_ch.final_block;
              state_r <= S_COMP_M;
              if (in_ch.final_block) begin
                buf_r  <= blk_masked;
                incr_r <= {1'b0, in_ch.tail_bytes, 3'b000};
              end else begin
                buf_r  <= blk_full;
                incr_r <= stb_pkg::BLOCK_BITS;
              end
            end
          end
        end
        S_COMP_M: begin
          if (crsp.done) begin
            h_r     <= crsp.h;
            cnt_r   <= '0;
            cy_n_r  <= 1'b0;
            cy_s_r  <= 1'b0;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          n_r[cnt_r*64 +: 64] <= sum_n[63:0];
          s_r[cnt_r*64 +: 64] <= sum_s[63:0];
          cy_n_r <= sum_n[64];
          cy_s_r <= sum_s[64];
          cnt_r  <= nxt_cnt;
          if (cnt_r == 3'd7) begin
            if (final_r) begin
              state_r <= S_COMP_N;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_COMP_N: begin
          if (crsp.done) begin
            h_r     <= crsp.h;
            state_r <= S_COMP_S;
          end
        end
        S_COMP_S: begin
          if (crsp.done) begin
            h_r         <= crsp.h;
            cnt_r       <= '0;
            out_valid_r <= 1'b1;
            out_word_r  <= crsp.h[511:448];
            out_last_r  <= 1'b0;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (out_last_r) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              cnt_r      <= nxt_cnt;
              out_word_r <= h_r[(3'd6 - cnt_r)*64 +: 64];
              out_last_r <= (nxt_cnt == last_idx);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT)
    else $error("digest word shown outside output phase");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    crsp.done |-> (state_r == S_COMP_M || state_r == S_COMP_N || state_r == S_COMP_S))
    else $error("compression finished with nobody waiting");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.digest_last) |=> in_ch.ready)
    else $error("input not released after last digest word");

endmodule
